/* hdl/annexb_pkg.sv */
// Package: item types and fixed constants of the Annex B start-code deframer.
`timescale 1ns / 1ps
package annexb_pkg;

    // Input item commands
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    // Byte that closes a start code
    localparam logic [7:0] START_CODE_END = 8'h01;

    // Header byte field masks
    localparam logic [7:0] HDR_FZ_MASK   = 8'h80;
    localparam logic [7:0] HDR_IDC_MASK  = 8'h60;
    localparam logic [7:0] HDR_TYPE_MASK = 8'h1f;
    localparam int         HDR_IDC_SHIFT = 5;

    // Held-back window and result queue sizes
    localparam int HELD_DEPTH  = 4;
    localparam int HELD_IDX_W  = 2;
    localparam int HELD_CNT_W  = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_OCC_W = 4;

    // Input item
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0]  nal_byte;
        logic [23:0] byte_index;
        logic        is_first;
        logic        is_last;
        logic        forbidden_zero;
        logic [1:0]  ref_idc;
        logic [4:0]  unit_type;
        logic        too_long;
    } t_out_item;

endpackage

/* hdl/annexb_nal_unit_deframer_unit.sv */
// Top level: Annex B start-code deframer with a held-back window and a result queue.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// The window compare and the counter update sit combinationally between the window
// registers and an eight-slot result queue. An item gives zero to four results,
// which queue behind any results already waiting and leave one per cycle while the
// receiver is ready; with the queue empty the first shows in the cycle after the item.
// The input is ready while at most four results wait. With the receiver always
// ready no more than four ever wait, so items flow at one per cycle; the input
// stalls only while the receiver holds off and more than four results wait.
// Synchronous active-low reset empties the queue and closes any open unit.
`timescale 1ns / 1ps
module annexb_nal_unit_deframer_unit #(
    parameter int INDEX_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  annexb_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output annexb_pkg::t_out_item o_out_item
);
    import annexb_pkg::*;

    localparam int LANES = HELD_DEPTH;

    // Window and unit state
    logic [7:0]            r_held [HELD_DEPTH];
    logic [7:0]            n_held [HELD_DEPTH];
    logic [HELD_CNT_W-1:0] r_hc, n_hc;
    logic                  r_open, n_open;
    logic [INDEX_BITS-1:0] r_count, n_count;
    logic [7:0]            r_hdr, n_hdr;
    logic                  r_ovf, n_ovf;

    // Result queue
    t_out_item             r_q [QUEUE_DEPTH];
    t_out_item             n_q [QUEUE_DEPTH];
    logic [QUEUE_OCC_W-1:0] r_occ, n_occ;

    logic                  in_acc;
    logic                  out_pop;
    logic                  start_code;
    logic [HELD_CNT_W-1:0] zeros;
    logic [HELD_CNT_W-1:0] emit_cnt;
    logic                  emit_last;
    logic                  first0;
    logic [7:0]            hdr_eff;
    logic [INDEX_BITS:0]   lane_sum [LANES];
    logic [INDEX_BITS:0]   k_sum;
    t_out_item             lane_res [LANES];

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_occ != '0);
    assign out_pop     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_occ <= QUEUE_OCC_W'(QUEUE_DEPTH - LANES));
    assign o_out_item  = r_q[0];

    // Find a start code ending at the incoming byte
    always_comb begin
        start_code = 1'b0;
        zeros      = HELD_CNT_W'(2);
        case (r_hc)
            HELD_CNT_W'(2): begin
                start_code = (r_held[0] == 8'h00) && (r_held[1] == 8'h00);
            end
            HELD_CNT_W'(3): begin
                start_code = (r_held[1] == 8'h00) && (r_held[2] == 8'h00);
                if (r_held[0] == 8'h00) begin
                    zeros = HELD_CNT_W'(3);
                end
            end
            HELD_CNT_W'(4): begin
                start_code = (r_held[2] == 8'h00) && (r_held[3] == 8'h00);
                if (r_held[1] == 8'h00) begin
                    zeros = HELD_CNT_W'(3);
                end
            end
            default: begin
                start_code = 1'b0;
            end
        endcase
        start_code = start_code && (i_in_item.command == CMD_DATA)
                     && (i_in_item.data_byte == START_CODE_END);
    end

    // Build the result lanes from the window; lane j carries held byte j
    assign first0  = (r_count == '0) && !r_ovf;
    assign hdr_eff = first0 ? r_held[0] : r_hdr;
    assign k_sum   = {1'b0, r_count} + (INDEX_BITS + 1)'(emit_cnt);

    always_comb begin
        logic [INDEX_BITS-1:0] idx;
        logic [INDEX_BITS+23:0] idx_ext;
        for (int j = 0; j < LANES; j++) begin
            lane_sum[j] = {1'b0, r_count} + (INDEX_BITS + 1)'(j);
            idx         = lane_sum[j][INDEX_BITS] ? '1 : lane_sum[j][INDEX_BITS-1:0];
            idx_ext     = {24'd0, idx};
            lane_res[j].nal_byte       = r_held[j];
            lane_res[j].byte_index     = idx_ext[23:0];
            lane_res[j].is_first       = (j == 0) && first0;
            lane_res[j].is_last        = emit_last && (emit_cnt == HELD_CNT_W'(j + 1));
            lane_res[j].forbidden_zero = (hdr_eff & HDR_FZ_MASK) != 8'h00;
            lane_res[j].ref_idc        = 2'((hdr_eff & HDR_IDC_MASK) >> HDR_IDC_SHIFT);
            lane_res[j].unit_type      = 5'(hdr_eff & HDR_TYPE_MASK);
            lane_res[j].too_long       = r_ovf || lane_sum[j][INDEX_BITS];
        end
    end

    // Advance the window and the unit counters on each accepted item
    always_comb begin
        for (int j = 0; j < HELD_DEPTH; j++) begin
            n_held[j] = r_held[j];
        end
        n_hc      = r_hc;
        n_open    = r_open;
        n_count   = r_count;
        n_hdr     = r_hdr;
        n_ovf     = r_ovf;
        emit_cnt  = '0;
        emit_last = 1'b0;
        if (in_acc) begin
            if (i_in_item.command == CMD_EOS) begin
                // flush held bytes, then drop back to waiting for a start code
                emit_cnt  = r_open ? r_hc : '0;
                emit_last = 1'b1;
                n_open    = 1'b0;
            end else if (start_code) begin
                // close the open unit before the start code and open a new one
                emit_cnt  = r_open ? (r_hc - zeros) : '0;
                emit_last = 1'b1;
                n_open    = 1'b1;
            end else if (r_hc == HELD_CNT_W'(HELD_DEPTH)) begin
                // window full: release the oldest byte and shift
                emit_cnt = r_open ? HELD_CNT_W'(1) : '0;
                for (int j = 0; j < HELD_DEPTH - 1; j++) begin
                    n_held[j] = r_held[j + 1];
                end
                n_held[HELD_DEPTH - 1] = i_in_item.data_byte;
            end else begin
                n_held[r_hc[HELD_IDX_W-1:0]] = i_in_item.data_byte;
                n_hc = r_hc + HELD_CNT_W'(1);
            end

            if ((i_in_item.command == CMD_EOS) || start_code) begin
                for (int j = 0; j < HELD_DEPTH; j++) begin
                    n_held[j] = 8'h00;
                end
                n_hc    = '0;
                n_count = '0;
                n_hdr   = 8'h00;
                n_ovf   = 1'b0;
            end else if (emit_cnt != '0) begin
                n_count = k_sum[INDEX_BITS] ? '1 : k_sum[INDEX_BITS-1:0];
                n_ovf   = r_ovf || k_sum[INDEX_BITS];
                n_hdr   = hdr_eff;
            end
        end
    end

    // Pop the head, shift the queue down, append the new lanes behind it
    always_comb begin
        logic [QUEUE_OCC_W-1:0] base;
        logic [QUEUE_OCC_W-1:0] off;
        base = r_occ - QUEUE_OCC_W'(out_pop);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (out_pop && (i < QUEUE_DEPTH - 1)) begin
                n_q[i] = r_q[(i + 1) % QUEUE_DEPTH];
            end else begin
                n_q[i] = r_q[i];
            end
            off = QUEUE_OCC_W'(i) - base;
            if ((QUEUE_OCC_W'(i) >= base) && (off < QUEUE_OCC_W'(emit_cnt))) begin
                n_q[i] = lane_res[off[HELD_IDX_W-1:0]];
            end
        end
        n_occ = base + QUEUE_OCC_W'(emit_cnt);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc    <= '0;
            r_open  <= 1'b0;
            r_count <= '0;
            r_hdr   <= 8'h00;
            r_ovf   <= 1'b0;
            r_occ   <= '0;
            for (int j = 0; j < HELD_DEPTH; j++) begin
                r_held[j] <= 8'h00;
            end
        end else begin
            r_hc    <= n_hc;
            r_open  <= n_open;
            r_count <= n_count;
            r_hdr   <= n_hdr;
            r_ovf   <= n_ovf;
            r_occ   <= n_occ;
            for (int j = 0; j < HELD_DEPTH; j++) begin
                r_held[j] <= n_held[j];
            end
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= QUEUE_OCC_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc <= HELD_CNT_W'(HELD_DEPTH))
        else $error("held window count out of range");

    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_first |->
            (o_out_item.byte_index == 24'd0) && !o_out_item.too_long)
        else $error("unit header byte without index zero");

    a_eos_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_item.command == CMD_EOS) |=> (r_hc == '0) && !r_open)
        else $error("end of stream left a unit open");

    a_no_emit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_open |=> r_occ == $past(r_occ) - QUEUE_OCC_W'($past(out_pop)))
        else $error("result produced with no unit open");
`endif

endmodule

/* bench/annexb_nal_unit_deframer_checker.sv */
// Checker: predicts the deframed NAL unit bytes and compares them with the block's results.
`timescale 1ns / 1ps
module annexb_nal_unit_deframer_checker #(
    parameter int INDEX_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  annexb_pkg::t_in_item  i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  annexb_pkg::t_out_item i_out_item,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count,
    output int                    o_unit_count,
    output int                    o_too_long_count
);
    import annexb_pkg::*;

    localparam longint POS_MAX = (longint'(1) << INDEX_BITS) - 1;

    // Predicted deframer state
    logic [7:0] window [HELD_DEPTH];
    int         win_cnt;
    logic       unit_is_open;
    longint     unit_pos;
    logic [7:0] hdr_byte;
    logic       pos_saturated;

    // Unit bytes still owed by the block, oldest first
    t_out_item  unit_bytes_due [$];

    int mismatches   = 0;
    int results_seen = 0;
    int units_opened = 0;
    int too_long_hit = 0;

    function automatic string item_text(t_out_item r);
        return $sformatf("byte %02h idx %0d first %0b last %0b fz %0b idc %0d type %0d long %0b",
                         r.nal_byte, r.byte_index, r.is_first, r.is_last,
                         r.forbidden_zero, r.ref_idc, r.unit_type, r.too_long);
    endfunction

    function automatic string diff_fields(t_out_item w, t_out_item g);
        string s = "";
        if (w.nal_byte !== g.nal_byte)             s = {s, " nal_byte"};
        if (w.byte_index !== g.byte_index)         s = {s, " byte_index"};
        if (w.is_first !== g.is_first)             s = {s, " is_first"};
        if (w.is_last !== g.is_last)               s = {s, " is_last"};
        if (w.forbidden_zero !== g.forbidden_zero) s = {s, " forbidden_zero"};
        if (w.ref_idc !== g.ref_idc)               s = {s, " ref_idc"};
        if (w.unit_type !== g.unit_type)           s = {s, " unit_type"};
        if (w.too_long !== g.too_long)             s = {s, " too_long"};
        return s;
    endfunction

    // Clear the window and counters; open a new unit or go back to hunting for a start code
    task automatic restart_unit(input logic open_it);
        int i;
        for (i = 0; i < HELD_DEPTH; i++) window[i] = 8'h00;
        win_cnt       = 0;
        unit_is_open  = open_it;
        unit_pos      = 0;
        hdr_byte      = 8'h00;
        pos_saturated = 1'b0;
    endtask

    // Queue one unit byte; latch the header on the first and saturate the position
    task automatic emit_unit_byte(input logic [7:0] b, input logic last);
        t_out_item r;
        logic      first;
        first = (unit_pos == 0) && !pos_saturated;
        if (first) hdr_byte = b;
        r.nal_byte       = b;
        r.byte_index     = unit_pos[23:0];
        r.is_first       = first;
        r.is_last        = last;
        r.forbidden_zero = (hdr_byte & HDR_FZ_MASK) != 8'h00;
        r.ref_idc        = 2'((hdr_byte & HDR_IDC_MASK) >> HDR_IDC_SHIFT);
        r.unit_type      = 5'(hdr_byte & HDR_TYPE_MASK);
        r.too_long       = pos_saturated;
        if (unit_pos < POS_MAX) unit_pos++;
        else pos_saturated = 1'b1;
        unit_bytes_due.push_back(r);
    endtask

    // Advance the predicted state by one input item
    task automatic deframe_item(input t_in_item it);
        int i;
        int zeros;
        int keep;
        // End of stream: flush whatever is held, then hunt for a start code again
        if (it.command == CMD_EOS) begin
            if (unit_is_open)
                for (i = 0; i < win_cnt; i++) emit_unit_byte(window[i], i + 1 == win_cnt);
            restart_unit(1'b0);
            return;
        end
        // Start code: release bytes ahead of the zeros, then open a fresh unit
        if (it.data_byte == START_CODE_END && win_cnt >= 2 &&
            window[win_cnt - 1] == 8'h00 && window[win_cnt - 2] == 8'h00) begin
            zeros = (win_cnt >= 3 && window[win_cnt - 3] == 8'h00) ? 3 : 2;
            keep  = win_cnt - zeros;
            if (unit_is_open)
                for (i = 0; i < keep; i++) emit_unit_byte(window[i], i + 1 == keep);
            restart_unit(1'b1);
            units_opened++;
            return;
        end
        // Ordinary byte: shift through a full window, else just hold it
        if (win_cnt == HELD_DEPTH) begin
            if (unit_is_open) emit_unit_byte(window[0], 1'b0);
            for (i = 0; i < HELD_DEPTH - 1; i++) window[i] = window[i + 1];
            window[HELD_DEPTH - 1] = it.data_byte;
        end else begin
            window[win_cnt] = it.data_byte;
            win_cnt++;
        end
    endtask

    initial restart_unit(1'b0);

    always @(posedge i_clk) begin
        t_out_item want;
        string     bad;
        if (!i_rst_n) begin
            restart_unit(1'b0);
            unit_bytes_due.delete();
        end else begin
            // Compare the result taken at this edge with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (i_out_item.too_long) too_long_hit++;
                if (unit_bytes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: %s", $time, item_text(i_out_item));
                end else begin
                    want = unit_bytes_due.pop_front();
                    bad  = diff_fields(want, i_out_item);
                    if (bad != "") begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] result %0d wrong in%s", $time, results_seen, bad);
                            $display("    expected %s", item_text(want));
                            $display("    actual   %s", item_text(i_out_item));
                        end
                    end
                end
            end
            // Predict the results of the item taken at this edge
            if (i_in_valid && i_in_ready) deframe_item(i_in_item);
        end
        o_fail_count     <= mismatches;
        o_pending        <= unit_bytes_due.size();
        o_result_count   <= results_seen;
        o_unit_count     <= units_opened;
        o_too_long_count <= too_long_hit;
    end

endmodule

/* bench/annexb_nal_unit_deframer_unit_tb.sv */
// Testbench top: drives byte streams into the Annex B deframer and reports the verdict.
`timescale 1ns / 1ps
module annexb_nal_unit_deframer_unit_tb;
    import annexb_pkg::*;

    // Narrow index, zero-extended onto the 24-bit field
    localparam int IDX_BITS    = 8;
    localparam int LONG_LEN    = 40;
    localparam int HOLD_CYCLES = 150;
    localparam int ITEM_TARGET = 210;
    localparam int EOS_MARK    = -1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int fail_count;
    int pending;
    int result_count;
    int unit_count;
    int too_long_count;

    int   items_sent    = 0;
    int   eos_sent      = 0;
    int   in_gap_max    = 0;
    int   out_stall_max = 0;
    logic hold_request  = 1'b0;

    annexb_nal_unit_deframer_unit #(.INDEX_BITS(IDX_BITS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    annexb_nal_unit_deframer_checker #(.INDEX_BITS(IDX_BITS)) chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_item       (out_item),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_unit_count     (unit_count),
        .o_too_long_count (too_long_count)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial begin
        #10ms;
        $display("Timeout: %0d items sent, %0d results still expected", items_sent, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: draw a stall per result, or hold off for a long stretch on request
    initial begin
        int stall;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_item.command   <= cmd;
        in_item.data_byte <= b;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (cmd == CMD_EOS) eos_sent++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(CMD_DATA, b);
    endtask

    task automatic send_eos();
        send_item(CMD_EOS, 8'($urandom_range(0, 255)));
    endtask

    // Payload bytes lean toward zeros and near-start-code values
    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 8'h00;
        if (r == 3) return START_CODE_END;
        if (r == 4) return 8'h03;
        return 8'($urandom_range(0, 255));
    endfunction

    // Pick idle behavior for both sides, including stretches with no idling
    task automatic pick_idling();
        case ($urandom_range(0, 4))
            0: begin in_gap_max = 0;  out_stall_max = 0;  end
            1: begin in_gap_max = 16; out_stall_max = 0;  end
            2: begin in_gap_max = 0;  out_stall_max = 16; end
            3: begin in_gap_max = 16; out_stall_max = 16; end
            default: begin in_gap_max = 3; out_stall_max = 3; end
        endcase
    endtask

    // Start code of either length, sometimes with a trailing zero on the earlier unit
    task automatic send_start_code();
        if ($urandom_range(0, 3) == 0) send_data(8'h00);
        if ($urandom_range(0, 1) == 1) send_data(8'h00);
        send_data(8'h00);
        send_data(8'h00);
        send_data(START_CODE_END);
    endtask

    // One well-formed unit with random content, now and then followed by noise
    task automatic send_random_unit();
        int kind;
        int len;
        int i;
        kind = $urandom_range(0, 19);
        send_start_code();
        // Back-to-back start codes leave an empty unit
        if (kind == 0) return;
        send_data(8'($urandom_range(0, 255)));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (i = 0; i < len; i++) send_data(payload_byte());
        case (kind)
            1: send_eos();
            2: begin
                // broken start code inside the unit
                send_data(8'h00);
                send_data(8'h00);
                send_data(8'h02);
            end
            3: begin
                // close the stream, then garbage before the next start code
                send_eos();
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++) send_data(payload_byte());
            end
            4: begin
                send_eos();
                send_eos();
            end
            default: ;
        endcase
    endtask

    // Long unit sent at full rate while the receiver holds off; backs up the queue until the input stalls
    task automatic send_long_unit();
        int i;
        in_gap_max    = 0;
        out_stall_max = 0;
        hold_request  = 1'b1;
        send_start_code();
        for (i = 0; i < LONG_LEN; i++) send_data(8'($urandom_range(2, 255)));
        send_eos();
    endtask

    initial begin
        int script [$];
        int i;
        logic long_done;
        // Directed: noise before any start code, four-byte code after a zero,
        // empty unit, header extremes, ignored byte on end of stream, idle end of stream
        script = '{8'hAA, 8'h00,
                   8'h00, 8'h00, 8'h01, 8'h65, 8'hFF,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                   8'h00, 8'h00, 8'h01,
                   8'hFF, 8'h00, EOS_MARK,
                   EOS_MARK,
                   8'h00, 8'h00, 8'h01, 8'h00, 8'h80, EOS_MARK};
        long_done = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < script.size(); i++) begin
            if (script[i] == EOS_MARK) send_eos();
            else send_data(8'(script[i]));
        end

        // Random units, with the long stalled unit once along the way
        while (items_sent < ITEM_TARGET) begin
            if (!long_done && items_sent > 60) begin
                send_long_unit();
                long_done = 1'b1;
            end
            pick_idling();
            send_random_unit();
        end
        send_eos();

        // Drain: wait for every owed byte, then watch for strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (pending != 0) $display("%0d expected results never arrived", pending);
        $display("Sent %0d items (%0d end of stream) opening %0d units; checked %0d result bytes.",
                 items_sent, eos_sent, unit_count, result_count);
        $display("Saw %0d too-long bytes; %0d mismatches.",
                 too_long_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
